// File: rtl/czp_pkg.sv
// czp_pkg: shared constants for the zero-padded CRC-32 stream unit.
// Holds the reflected CRC-32 nibble table and the CRC start value.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package czp_pkg;

    typedef logic [31:0] t_crc;

    localparam t_crc CRC_INIT = 32'hFFFF_FFFF;

    // Reflected CRC-32 (0xEDB88320) advanced over four zero bits, one entry per low nibble
    localparam t_crc NIBBLE_TABLE [16] = '{
        32'h0000_0000, 32'h1DB7_1064, 32'h3B6E_20C8, 32'h26D9_30AC,
        32'h76DC_4190, 32'h6B6B_51F4, 32'h4DB2_6158, 32'h5005_713C,
        32'hEDB8_8320, 32'hF00F_9344, 32'hD6D6_A3E8, 32'hCB61_B38C,
        32'h9B64_C2B0, 32'h86D3_D2D4, 32'hA00A_E278, 32'hBDBD_F21C
    };

endpackage

`default_nettype wire

// File: rtl/czp_nibble_unit.sv
// czp_nibble_unit: shared CRC update step, advances the CRC by four bits.
// Uses the nibble table from czp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module czp_nibble_unit (
    input  wire czp_pkg::t_crc i_crc,
    output czp_pkg::t_crc      o_crc
);
    import czp_pkg::*;

    // Shift out the low nibble and fold in its table entry
    assign o_crc = {4'b0000, i_crc[31:4]} ^ NIBBLE_TABLE[i_crc[3:0]];

endmodule

`default_nettype wire

// File: rtl/crc32_zero_padded_stream_unit.sv
// crc32_zero_padded_stream_unit: top level, byte stream in, CRC-32 word out.
// Uses czp_pkg and czp_nibble_unit (one shared nibble step under a small sequencer).
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_stall   | i_data_byte, i_last_byte
//   out     | output    | o_out_valid / i_out_stall | o_crc_value
//
// Each byte runs one nibble per cycle through the shared table step.
// A final byte adds 0 to 3 zero pad bytes, both nibble steps each, and then goes to
// load the result register; that load waits while a prior result is still stalled.
// The result register lets a new message start while its word waits on i_out_stall.
// Synchronous active-low reset returns the CRC to all ones and the phase to zero.
`timescale 1ns / 1ps
`default_nettype none

module crc32_zero_padded_stream_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // input channel
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire  [7:0] i_data_byte,
    input  wire        i_last_byte,
    // output channel
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [31:0] o_crc_value
);
    import czp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_NIB2,
        S_PAD,
        S_DONE
    } t_state;

    t_state     r_state, n_state;
    t_crc       r_crc, n_crc;
    logic [1:0] r_phase, n_phase;
    logic       r_last, n_last;
    logic       r_out_valid, n_out_valid;
    t_crc       r_out_crc, n_out_crc;

    t_crc       unit_in;
    t_crc       unit_out;
    logic       in_accept;
    logic       out_free;
    logic [1:0] phase_inc;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign phase_inc = r_phase + 2'd1;

    // Shared unit input: fold the new byte in on accept, else continue
    assign unit_in = in_accept ? (r_crc ^ {24'd0, i_data_byte}) : r_crc;

    czp_nibble_unit u_nibble (
        .i_crc (unit_in),
        .o_crc (unit_out)
    );

    // Sequencer next-state logic
    always_comb begin
        n_state     = r_state;
        n_crc       = r_crc;
        n_phase     = r_phase;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_crc   = r_out_crc;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_crc   = unit_out;
                    n_last  = i_last_byte;
                    n_state = S_NIB2;
                end
            end
            S_NIB2: begin
                n_crc   = unit_out;
                n_phase = phase_inc;
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (phase_inc != 2'd0) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PAD: begin
                // zero pad byte: no XOR, just the first nibble step
                n_crc   = unit_out;
                n_state = S_NIB2;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_crc   = ~r_crc;
                    n_crc       = CRC_INIT;
                    n_phase     = 2'd0;
                    n_last      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_crc       <= CRC_INIT;
            r_phase     <= 2'd0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_crc       <= n_crc;
            r_phase     <= n_phase;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
        r_out_crc <= n_out_crc;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_out_crc;

endmodule

`default_nettype wire

// File: rtl/czp_checker.sv
// czp_checker: port-level checks for crc32_zero_padded_stream_unit.
// Bound to the top level below; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module czp_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [31:0] o_crc_value
);

    // A stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_crc_value))
        else $error("result word changed while stalled");

    // Every accepted byte keeps the unit busy for its second nibble
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before the byte finished");

    // A new result only appears after the unit was busy finishing a message
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result word appeared without a finishing message");

endmodule

bind crc32_zero_padded_stream_unit czp_checker u_czp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_crc_value (o_crc_value)
);

`default_nettype wire

// File: tb/sv/crc32_zero_padded_stream_checker.sv
// crc32_zero_padded_stream_checker: watches both channels of the CRC-32 stream unit.
// It predicts each CRC word from the accepted bytes and compares it with the output.
// Depends on czp_pkg for the CRC type and start value.
`timescale 1ns / 1ps

module crc32_zero_padded_stream_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_last_byte,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [31:0] i_crc_value,
    output int          o_mismatch_count,
    output int          o_words_pending
);
    import czp_pkg::*;

    // predicted state of the block
    t_crc      crc_running = CRC_INIT;
    logic [1:0] pad_phase  = 2'd0;

    // CRC words still owed by the block, oldest first
    t_crc      crc_words_due [$];

    // one byte through the reflected CRC-32, LSB first
    function automatic t_crc crc_shift_byte(input t_crc crc, input logic [7:0] data);
        t_crc acc;
        acc = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ 32'hEDB8_8320;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    initial begin
        o_mismatch_count = 0;
        o_words_pending  = 0;
    end

    always @(posedge i_clk) begin
        t_crc want;
        if (i_rst_n) begin
            // output word: compare with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (crc_words_due.size() == 0) begin
                    $error("crc_value: unexpected word, expected none, actual %08h",
                           i_crc_value);
                    o_mismatch_count++;
                end else begin
                    want = crc_words_due.pop_front();
                    if (i_crc_value !== want) begin
                        $error("crc_value mismatch: expected %08h, actual %08h",
                               want, i_crc_value);
                        o_mismatch_count++;
                    end
                end
            end
            // input word: absorb, and on the final byte pad to a multiple of four and predict
            if (i_in_valid && !i_in_stall) begin
                crc_running = crc_shift_byte(crc_running, i_data_byte);
                pad_phase   = pad_phase + 2'd1;
                if (i_last_byte) begin
                    while (pad_phase != 2'd0) begin
                        crc_running = crc_shift_byte(crc_running, 8'h00);
                        pad_phase   = pad_phase + 2'd1;
                    end
                    crc_words_due.push_back(~crc_running);
                    crc_running = CRC_INIT;
                end
            end
            o_words_pending = crc_words_due.size();
        end
    end

endmodule

// File: tb/sv/tb_crc32_zero_padded_stream_unit.sv
// tb_crc32_zero_padded_stream_unit: stimulus and verdict for the CRC-32 stream unit.
// Drives byte messages under several idle mixes; the checker module does the prediction.
// Depends on czp_pkg, crc32_zero_padded_stream_unit and crc32_zero_padded_stream_checker.
`timescale 1ns / 1ps

module tb_crc32_zero_padded_stream_unit;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_BYTES   = 750;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_crc_value;

    int mismatch_count;
    int words_pending;

    // idle mix, shared by the sender and receiver processes
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    bit hold_req        = 1'b0;

    int bytes_sent   = 0;
    int msgs_sent    = 0;
    int quiet_cycles = 0;

    crc32_zero_padded_stream_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_crc_value (o_crc_value)
    );

    crc32_zero_padded_stream_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_crc_value      (o_crc_value),
        .o_mismatch_count (mismatch_count),
        .o_words_pending  (words_pending)
    );

    // clock
    initial begin
        forever begin
            #1 i_clk = ~i_clk;
        end
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_crc32_zero_padded_stream_unit: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    i_out_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // offer one byte, with optional idle cycles first, and wait for it to be taken
    task automatic send_byte(input logic [7:0] data, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= data;
        i_last_byte <= last;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        bytes_sent++;
        if (last) begin
            msgs_sent++;
        end
    endtask

    task automatic send_message(input logic [7:0] msg [$]);
        for (int k = 0; k < msg.size(); k++) begin
            send_byte(msg[k], k == msg.size() - 1);
        end
    endtask

    task automatic send_random_message(input int len);
        for (int k = 0; k < len; k++) begin
            send_byte(8'($urandom), k == len - 1);
        end
    endtask

    initial begin
        int phase;
        int len;
        logic [7:0] msg [$];

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every pad count, extreme bytes, phase wrap past four
        msg = '{8'h00};                                    send_message(msg);
        msg = '{8'hFF};                                    send_message(msg);
        msg = '{8'hFF, 8'h00};                             send_message(msg);
        msg = '{8'hA5, 8'h5A, 8'hFF};                      send_message(msg);
        msg = '{8'h00, 8'hFF, 8'h01, 8'h80};               send_message(msg);
        msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};        send_message(msg);
        msg = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20}; send_message(msg);

        // random messages; the idle mix changes every fifth of the run
        while (bytes_sent < RANDOM_BYTES + 22) begin
            phase = ((bytes_sent - 22) * 5) / RANDOM_BYTES;
            case (phase)
                0: begin
                    sender_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 51; recv_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;  recv_stall_pct = 51;
                end
                3: begin
                    sender_idle_pct = 15; recv_stall_pct = 15;
                end
                default: begin
                    // long receiver hold-off while bytes keep coming
                    if (sender_idle_pct != 0 || recv_stall_pct != 0) begin
                        hold_req = 1'b1;
                    end
                    sender_idle_pct = 0;  recv_stall_pct = 0;
                end
            endcase
            // mostly short messages, a few long ones
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(40, 9);
            end else begin
                len = $urandom_range(8, 1);
            end
            send_random_message(len);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;

        // drain, then let any stray word show up
        wait (words_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d messages, %0d bytes, lengths 1 to 40, all pad counts,",
                 msgs_sent, bytes_sent);
        $display("four idle mixes and a %0d-cycle output hold-off", HOLD_CYCLES);
        if (mismatch_count == 0 && words_pending == 0) begin
            $display("tb_crc32_zero_padded_stream_unit: PASS");
        end else begin
            $display("tb_crc32_zero_padded_stream_unit: FAIL");
        end
        $finish;
    end

endmodule
